// File: src/tsk_pkg.sv
`timescale 1ns / 1ps

package tsk_pkg;

   localparam int NODES_DEF = 16;

   typedef enum logic [1:0] {
      CMD_ADD_NODE = 2'd0,
      CMD_ADD_EDGE = 2'd1,
      CMD_SORT     = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SORT = 1'b1
   } state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] from_node;
      logic [3:0] to_node;
   } req_type;

   typedef struct packed {
      logic [3:0] node_index;
      logic       node_valid;
      logic       cycle_error;
      logic       last;
   } rsp_type;

   // per-cycle commands broadcast to every node cell
   typedef struct packed {
      logic clear;
      logic add_node;
      logic add_edge;
      logic start;
      logic step;
   } cell_ctrl_type;

endpackage

// File: src/tsk_cell.sv
`timescale 1ns / 1ps

// One graph node: presence, incoming-edge column, in-degree and sort state.
module tsk_cell #(
   parameter int NODES = tsk_pkg::NODES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tsk_pkg::cell_ctrl_type ctrl,
   input  logic                   is_src,
   input  logic                   is_dst,
   input  logic [NODES-1:0]       src_hot,
   input  logic [NODES-1:0]       pick_hot,
   input  logic                   claim_in,
   output logic                   claim_out,
   output logic                   pick,
   output logic                   pend
);

   localparam int DEG_W = $clog2(NODES + 1);

   logic             present_ff, present_in;
   logic             emitted_ff, emitted_in;
   logic [NODES-1:0] in_col_ff, in_col_in;
   logic [DEG_W-1:0] deg_ff, deg_in;
   logic [DEG_W-1:0] work_ff, work_in;
   logic             ready;
   logic             dup;
   logic             dec;

   assign ready     = present_ff && !emitted_ff && (work_ff == '0);
   assign pick      = ready && !claim_in;
   assign claim_out = claim_in || ready;
   assign pend      = present_ff && !emitted_ff;
   assign dup       = |(in_col_ff & src_hot);
   assign dec       = (|(in_col_ff & pick_hot)) && (work_ff != '0);

   always_comb begin
      present_in = present_ff;
      emitted_in = emitted_ff;
      in_col_in  = in_col_ff;
      deg_in     = deg_ff;
      work_in    = work_ff;
      if (ctrl.clear) begin
         present_in = 1'b0;
         emitted_in = 1'b0;
         in_col_in  = '0;
         deg_in     = '0;
         work_in    = '0;
      end else begin
         if (ctrl.add_node && is_src) begin
            present_in = 1'b1;
         end
         if (ctrl.add_edge) begin
            if (is_src || is_dst) begin
               present_in = 1'b1;
            end
            if (is_dst && !dup) begin
               in_col_in = in_col_ff | src_hot;
               deg_in    = deg_ff + DEG_W'(1);
            end
         end
         if (ctrl.start) begin
            emitted_in = 1'b0;
            work_in    = deg_ff;
         end
         if (ctrl.step) begin
            if (pick) begin
               emitted_in = 1'b1;
            end
            if (dec) begin
               work_in = work_ff - DEG_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         emitted_ff <= 1'b0;
         in_col_ff  <= '0;
         deg_ff     <= '0;
         work_ff    <= '0;
      end else begin
         present_ff <= present_in;
         emitted_ff <= emitted_in;
         in_col_ff  <= in_col_in;
         deg_ff     <= deg_in;
         work_ff    <= work_in;
      end
   end

endmodule

// File: src/topological_sort_kahn.sv
`timescale 1ns / 1ps
// Add node, add edge and clear give no transfer.
// Sort: each picked node is held and sent once the next node is picked or the
// sort closes; a closing status follows when no node was emitted or nodes remain.
// The cell chain gives a single pick per cycle while rsp_stall does not hold it.
// Reset (synchronous, active high) empties the graph and idles the block.
module topological_sort_kahn #(
   parameter int NODES = tsk_pkg::NODES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsk_pkg::rsp_type rsp_data
);

   // ---------------------------------------------------------------
   // Node cells. Each cell holds the edges that end at its node, so an
   // emitted node is broadcast one-hot and every successor decrements
   // its own working in-degree in the same cycle. The claim chain
   // runs from cell 0 upward: the first ready cell takes the pick,
   // which gives the lowest-index tie-break.
   // ---------------------------------------------------------------
   tsk_pkg::cell_ctrl_type ctrl;
   logic [NODES-1:0]       src_hot;
   logic [NODES-1:0]       dst_hot;
   logic [NODES-1:0]       pick_hot;
   logic [NODES-1:0]       pend_vec;
   logic [NODES:0]         claim;
   logic                   src_ok;
   logic                   dst_ok;
   logic [3:0]             pick_idx;
   logic                   any_ready;
   logic                   leftover;

   assign src_ok   = 32'(req_data.from_node) < NODES;
   assign dst_ok   = 32'(req_data.to_node) < NODES;
   assign claim[0] = 1'b0;
   assign any_ready = claim[NODES];
   assign leftover  = |pend_vec;

   always_comb begin
      for (int i = 0; i < NODES; i++) begin
         src_hot[i] = src_ok && (32'(req_data.from_node) == i);
         dst_hot[i] = dst_ok && (32'(req_data.to_node) == i);
      end
   end

   // one-hot pick to index; only nodes below 16 can ever be present
   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < NODES; i++) begin
         if (pick_hot[i]) begin
            pick_idx = pick_idx | 4'(i);
         end
      end
   end

   for (genvar g = 0; g < NODES; g++) begin : g_cell
      tsk_cell #(
         .NODES (NODES)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .is_src    (src_hot[g]),
         .is_dst    (dst_hot[g]),
         .src_hot   (src_hot),
         .pick_hot  (pick_hot),
         .claim_in  (claim[g]),
         .claim_out (claim[g+1]),
         .pick      (pick_hot[g]),
         .pend      (pend_vec[g])
      );
   end

   // ---------------------------------------------------------------
   // Sequencer. A picked node is held in prev until the next pick or the
   // close, so that the last flag is known when it goes out: it is last only
   // if nothing else became ready and no node is left over.
   // ---------------------------------------------------------------
   tsk_pkg::state_type state_ff, state_in;
   logic               have_prev_ff, have_prev_in;
   logic [3:0]         prev_ff, prev_in;
   logic               rsp_valid_ff;
   tsk_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rsp_load;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != tsk_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsk_pkg::ST_IDLE: begin
            if (req_valid && (req_data.cmd == tsk_pkg::CMD_SORT)) begin
               state_in = tsk_pkg::ST_SORT;
            end
         end
         tsk_pkg::ST_SORT: begin
            if (out_free && !any_ready && !(leftover && have_prev_ff)) begin
               state_in = tsk_pkg::ST_IDLE;
            end
         end
         default: state_in = tsk_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      ctrl         = '0;
      rsp_load     = 1'b0;
      rsp_data_in  = '0;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      case (state_ff)
         tsk_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd)
                  tsk_pkg::CMD_ADD_NODE: ctrl.add_node = 1'b1;
                  tsk_pkg::CMD_ADD_EDGE: ctrl.add_edge = src_ok && dst_ok;
                  tsk_pkg::CMD_SORT: begin
                     ctrl.start   = 1'b1;
                     have_prev_in = 1'b0;
                  end
                  tsk_pkg::CMD_CLEAR:    ctrl.clear = 1'b1;
                  default:               ctrl.clear = 1'b0;
               endcase
            end
         end
         tsk_pkg::ST_SORT: begin
            if (out_free) begin
               if (any_ready) begin
                  ctrl.step    = 1'b1;
                  prev_in      = pick_idx;
                  have_prev_in = 1'b1;
                  if (have_prev_ff) begin
                     rsp_load               = 1'b1;
                     rsp_data_in.node_index = prev_ff;
                     rsp_data_in.node_valid = 1'b1;
                  end
               end else begin
                  rsp_load = 1'b1;
                  if (have_prev_ff) begin
                     // pending node goes out; last only if nothing is stuck
                     rsp_data_in.node_index = prev_ff;
                     rsp_data_in.node_valid = 1'b1;
                     rsp_data_in.last       = !leftover;
                     have_prev_in           = 1'b0;
                  end else begin
                     // closing status: cycle flag when nodes remain
                     rsp_data_in.cycle_error = leftover;
                     rsp_data_in.last        = 1'b1;
                  end
               end
            end
         end
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsk_pkg::ST_IDLE;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int HOLD_CYCLES  = 150;
   localparam int RANDOM_ITEMS = 190;
   localparam int DRAIN_CYCLES = 20;

   // Scoreboard: mirrors the graph and precomputes every sort's node order.
   class topo_scoreboard;
      logic [15:0]      present;
      logic [15:0]      succ [16];   // succ[s][d] set when edge s->d is stored
      logic [4:0]       indeg [16];
      logic [15:0]      done_mask;
      tsk_pkg::rsp_type pending [$];
      int               mismatches;
      int               results_seen;
      int               sorts_run;
      int               cycle_flags;
      int               requests;

      function new();
         clear_graph();
         mismatches   = 0;
         results_seen = 0;
         sorts_run    = 0;
         cycle_flags  = 0;
         requests     = 0;
      endfunction

      function void clear_graph();
         present   = '0;
         done_mask = '0;
         for (int i = 0; i < 16; i++) begin
            succ[i]  = '0;
            indeg[i] = '0;
         end
      endfunction

      function void push_rsp(logic [3:0] idx, logic v, logic c, logic l);
         tsk_pkg::rsp_type e;
         e.node_index  = idx;
         e.node_valid  = v;
         e.cycle_error = c;
         e.last        = l;
         pending.insert(pending.size(), e);
      endfunction

      // Kahn walk, lowest ready index first; the node of a step is held back
      // one round so the final one can carry last.
      function void predict_order();
         logic [4:0] deg [16];
         logic [3:0] prev;
         logic       have_prev;
         int         pick;
         for (int i = 0; i < 16; i++) deg[i] = indeg[i];
         done_mask = '0;
         have_prev = 1'b0;
         prev      = '0;
         do begin
            pick = -1;
            for (int i = 0; i < 16 && pick < 0; i++)
               if (present[i] && !done_mask[i] && deg[i] == 0) pick = i;
            if (pick >= 0) begin
               if (have_prev) push_rsp(prev, 1'b1, 1'b0, 1'b0);
               prev            = pick[3:0];
               have_prev       = 1'b1;
               done_mask[pick] = 1'b1;
               for (int j = 0; j < 16; j++)
                  if (succ[pick][j] && deg[j] > 0) deg[j] = deg[j] - 5'd1;
            end
         end while (pick >= 0);

         if ((present & ~done_mask) != '0) begin
            if (have_prev) push_rsp(prev, 1'b1, 1'b0, 1'b0);
            push_rsp(4'd0, 1'b0, 1'b1, 1'b1);
            cycle_flags++;
         end else if (have_prev) begin
            push_rsp(prev, 1'b1, 1'b0, 1'b1);
         end else begin
            push_rsp(4'd0, 1'b0, 1'b0, 1'b1);
         end
      endfunction

      function void note_request(tsk_pkg::req_type r);
         requests++;
         case (r.cmd)
            tsk_pkg::CMD_ADD_NODE: present[r.from_node] = 1'b1;
            tsk_pkg::CMD_ADD_EDGE: begin
               present[r.from_node] = 1'b1;
               present[r.to_node]   = 1'b1;
               if (!succ[r.from_node][r.to_node]) begin
                  succ[r.from_node][r.to_node] = 1'b1;
                  indeg[r.to_node] = indeg[r.to_node] + 5'd1;
               end
            end
            tsk_pkg::CMD_SORT: begin
               sorts_run++;
               predict_order();
            end
            default: clear_graph();
         endcase
      endfunction

      function void check_response(tsk_pkg::rsp_type got);
         tsk_pkg::rsp_type want;
         results_seen++;
         if (pending.size() == 0) begin
            if (mismatches < 10)
               $display("mismatch: unexpected result idx=%0d valid=%0b cyc=%0b last=%0b",
                        got.node_index, got.node_valid, got.cycle_error, got.last);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got.node_index != want.node_index || got.node_valid != want.node_valid ||
             got.cycle_error != want.cycle_error || got.last != want.last) begin
            if (mismatches < 10)
               $display({"mismatch: expected idx=%0d valid=%0b cyc=%0b last=%0b,",
                         " got idx=%0d valid=%0b cyc=%0b last=%0b"},
                        want.node_index, want.node_valid, want.cycle_error, want.last,
                        got.node_index, got.node_valid, got.cycle_error, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tsk_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tsk_pkg::rsp_type rsp_data;

   bit quiet    = 1'b0;   // no idling on either side while set
   bit hold_req = 1'b0;   // asks the receiver for one long hold-off

   topo_scoreboard sc = new();

   topological_sort_kahn i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Monitor: outputs only move on NBA updates, so values read right after the
   // edge are the ones the edge sampled.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sc.check_response(rsp_data);
         if (req_valid && !req_stall) sc.note_request(req_data);
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here so the
   // block fills up and pushes back on the request side.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 10);
         end
      end
   end

   // One request transfer, with optional idle cycles in front of it.
   task automatic send_item(input tsk_pkg::cmd_type c, input int f, input int t);
      tsk_pkg::req_type r;
      r.cmd       = c;
      r.from_node = 4'(f);
      r.to_node   = 4'(t);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 10) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sort_graph();
      send_item(tsk_pkg::CMD_SORT, $urandom_range(0, 15), $urandom_range(0, 15));
   endtask

   task automatic clear_graph_req();
      send_item(tsk_pkg::CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15));
   endtask

   initial begin
      int perm [16];
      int a, b, n, k, kind, tmp, phase, start_reqs;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      sort_graph();                                 // empty graph: single status
      send_item(tsk_pkg::CMD_ADD_NODE, 15, 0);
      send_item(tsk_pkg::CMD_ADD_NODE, 0, 15);
      send_item(tsk_pkg::CMD_ADD_NODE, 0, 0);       // repeated node
      sort_graph();                                 // tie-break: 0 before 15
      send_item(tsk_pkg::CMD_ADD_EDGE, 15, 0);
      send_item(tsk_pkg::CMD_ADD_EDGE, 15, 0);      // duplicate edge ignored
      sort_graph();
      send_item(tsk_pkg::CMD_ADD_EDGE, 7, 7);       // self edge: never ready
      sort_graph();
      sort_graph();                                 // sort leaves graph intact
      clear_graph_req();
      sort_graph();
      send_item(tsk_pkg::CMD_ADD_EDGE, 3, 4);       // two-node loop
      send_item(tsk_pkg::CMD_ADD_EDGE, 4, 3);
      send_item(tsk_pkg::CMD_ADD_NODE, 9, 0);
      sort_graph();
      clear_graph_req();
      send_item(tsk_pkg::CMD_ADD_EDGE, 0, 15);      // endpoints become present
      send_item(tsk_pkg::CMD_ADD_EDGE, 10, 5);
      send_item(tsk_pkg::CMD_ADD_NODE, 12, 0);
      send_item(tsk_pkg::CMD_ADD_EDGE, 5, 15);
      sort_graph();
      clear_graph_req();

      // --- random ---
      start_reqs = sc.requests;
      phase      = 0;
      while (sc.requests - start_reqs < RANDOM_ITEMS) begin
         for (k = 0; k < 16; k++) perm[k] = k;
         for (k = 15; k > 0; k--) begin
            b       = $urandom_range(0, k);
            tmp     = perm[k];
            perm[k] = perm[b];
            perm[b] = tmp;
         end
         quiet = (phase >= 8 && phase < 14);
         kind  = (phase == 2) ? 6 : $urandom_range(0, 9);

         if (phase == 2) hold_req = 1'b1;   // receiver backs off; sorts pile up

         if (kind <= 5 || kind == 8) begin
            // DAG respecting the shuffled rank; a back edge forces a cycle
            if ($urandom_range(0, 4) != 0) clear_graph_req();
            n = $urandom_range(1, 6);
            repeat (n) send_item(tsk_pkg::CMD_ADD_NODE, perm[$urandom_range(0, 15)],
                                 $urandom_range(0, 15));
            n = $urandom_range(0, 8);
            repeat (n) begin
               a = $urandom_range(0, 14);
               b = $urandom_range(a + 1, 15);
               send_item(tsk_pkg::CMD_ADD_EDGE, perm[a], perm[b]);
            end
            if (kind == 8) begin
               a = $urandom_range(0, 14);
               b = $urandom_range(a + 1, 15);
               send_item(tsk_pkg::CMD_ADD_EDGE, perm[a], perm[b]);
               send_item(tsk_pkg::CMD_ADD_EDGE, perm[b], perm[a]);
            end
            sort_graph();
            if ($urandom_range(0, 3) == 0) sort_graph();
         end else if (kind <= 7) begin
            // chain through a random node order, full length when kind is 6
            clear_graph_req();
            n = (kind == 6) ? 15 : $urandom_range(2, 15);
            for (k = 0; k < n; k++)
               send_item(tsk_pkg::CMD_ADD_EDGE, perm[k], perm[k + 1]);
            sort_graph();
            if (phase == 2) begin
               sort_graph();
               sort_graph();
            end
         end else begin
            // noise: anything goes
            repeat (6) send_item(tsk_pkg::cmd_type'(2'($urandom_range(0, 3))),
                                 $urandom_range(0, 15), $urandom_range(0, 15));
            sort_graph();
         end
         phase++;
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (sc.pending.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d request transfers and %0d sorts in %0d random phases.",
               sc.requests, sc.sorts_run, phase);
      $display("Checked %0d results, %0d of the sorts ended in a cycle report, %0d mismatches.",
               sc.results_seen, sc.cycle_flags, sc.mismatches);
      if (sc.mismatches == 0 && sc.pending.size() == 0) begin
         $display("PASS topological_sort_kahn");
      end else begin
         $display("FAIL topological_sort_kahn");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("timeout: %0d results still expected", sc.pending.size());
      $display("FAIL topological_sort_kahn");
      $finish;
   end

endmodule
